// ----- src/rotation_predicted_residual_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rotation predicted residual encoder
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ROTATION_PREDICTED_RESIDUAL_ENCODER_DEFINES_SVH
`define ROTATION_PREDICTED_RESIDUAL_ENCODER_DEFINES_SVH

// implication checked at every clock edge outside reset
`define RPRE_ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPRE_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rpre_pkg.sv -----
// ----------------------------------------------------------------------------
// rpre_pkg
// Shared constants and types of the rotation predicted residual encoder.
// ----------------------------------------------------------------------------
package rpre_pkg;
	localparam int MAX_WIDTH_DEF       = 64;
	localparam int MAX_HEIGHT_DEF      = 64;
	localparam int COEFF_FRAC_BITS_DEF = 14;

	localparam int DIM_W   = 7;
	localparam int COEFF_W = 16;
	localparam int BYTE_W  = 8;
	localparam int OFF_W   = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN    = 2'd3;

	localparam logic CMD_KEY   = 1'b0;
	localparam logic CMD_INTER = 1'b1;

	// residual nibble: ((cur - pred) >>> 4) + 8, 4 bits
	function automatic logic [3:0] resid_nib(input logic [7:0] cur, input logic [7:0] pred);
		logic [8:0] t;
		t = {1'b0, cur} + 9'd256 - {1'b0, pred};
		return t[7:4] + 4'd8;
	endfunction
endpackage

// ----- src/rpre_mac.sv -----
// ----------------------------------------------------------------------------
// rpre_mac
// Shared multiply-accumulate unit: one signed product per cycle while en is high, added to or subtracted from an acc.
// ----------------------------------------------------------------------------
module rpre_mac #(
	parameter int A_W   = 12,
	parameter int ACC_W = 40
) (
	input  logic                     clk,
	input  logic                     clr,
	input  logic                     en,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [rpre_pkg::COEFF_W-1:0] b,
	input  logic                     neg,
	input  logic signed [ACC_W-1:0]  init,
	output logic signed [ACC_W-1:0]  acc
);
	import rpre_pkg::*;
	logic signed [A_W+COEFF_W-1:0] prod;
	logic signed [ACC_W-1:0]       acc_q;

	assign prod = a * b;
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= init;
		end else if (en) begin
			if (neg) acc_q <= acc_q - ACC_W'(prod);
			else     acc_q <= acc_q + ACC_W'(prod);
		end
	end
endmodule

// ----- src/rotation_predicted_residual_encoder.sv -----
// ----------------------------------------------------------------------------
// rotation_predicted_residual_encoder
// Codes raster RGB pixels as RGB565 (key) or rotation-predicted nibbles.
// ----------------------------------------------------------------------------
// One pixel is taken per transaction; s_tdata = {blue, green, red} over
// {command} in tuser. Key pixels give two bytes, inter pixels one (even p)
// or two (odd p). A key pixel passes through accept, result and two output
// transactions. An inter pixel passes through accept, the coordinate
// reduction steps, prediction read, result and its output transactions:
// a shift-subtract divider splits p into x and y over YW steps (6 for 64
// lines), the single shared multiplier forms the four rotation products in
// turn, a further state captures the second coordinate, then a shared
// adder-subtractor wraps x and then y into the frame one step per cycle (no step
// for an identity rotation, at most about four for a 64x64 frame, up to
// about 70 for a frame one pixel wide or one line high), one state reads
// the prediction and one builds the result. The block waits while the output is
// held off. The block takes no new pixel until all results have left.
// Both frame stores live in one memory with the bank bit on top of the
// address; entries have no reset and must be written before they are read.
// ----------------------------------------------------------------------------
module rotation_predicted_residual_encoder #(
	parameter int MAX_WIDTH       = rpre_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = rpre_pkg::MAX_HEIGHT_DEF,
	parameter int COEFF_FRAC_BITS = rpre_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	input  logic        s_tuser,  // command
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_byte[7:0], byte_offset[20:8], frame_done[21]
	output logic        m_tlast   // last
);
	import rpre_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int NW    = AW + 1;
	localparam int DW    = (XW > YW ? XW : YW) + 2;
	localparam int ACC_W = DW + COEFF_W + 4;
	localparam int SH    = COEFF_FRAC_BITS + 1;
	localparam int FW    = ACC_W - SH;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_DIV = 4'd1, ST_M0 = 4'd2, ST_M1 = 4'd3,
		ST_M2 = 4'd4, ST_M3 = 4'd5, ST_M4 = 4'd6, ST_MY = 4'd7, ST_MX = 4'd8,
		ST_RD = 4'd9, ST_RES = 4'd10, ST_OUT0 = 4'd11, ST_OUT1 = 4'd12;

	// registers
	logic [DIM_W-1:0]   width_q, height_q;
	logic signed [COEFF_W-1:0] cos_q, sin_q;
	logic               bank_q;
	logic [NW-1:0]      pix_q;
	logic [3:0]         held_q;
	logic [3:0]         st_q;

	logic               cmd_q;
	logic [7:0]         r_q, g_q, b_q;
	logic [NW-1:0]      p_q, npix_q;
	logic [XW:0]        w_q;
	logic [YW:0]        h_q;
	logic [NW-1:0]      rem_q, dsr_q;
	logic [3:0]         dcnt_q;
	logic [YW-1:0]      y_q;
	logic               end_q;
	logic signed [FW-1:0] mx_q, my_q;

	logic [7:0]         ob_q;
	logic [OFF_W-1:0]   off_q;
	logic               done_q, ov_q;
	logic [7:0]         ob2_q;
	logic [OFF_W-1:0]   off2_q;
	logic               done2_q, two_q;

	// clamped size
	logic [XW:0]   w_eff;
	logic [YW:0]   h_eff;
	logic [NW-1:0] npix_eff, p_eff;
	always_comb begin
		if (width_q == '0) w_eff = (XW+1)'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
		else w_eff = (XW+1)'(width_q);
		if (height_q == '0) h_eff = (YW+1)'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
		else h_eff = (YW+1)'(height_q);
		npix_eff = NW'(w_eff) * NW'(h_eff);
		p_eff    = (pix_q >= npix_eff) ? '0 : pix_q;
	end

	// memory: both banks
	logic [23:0] mem [0:2*(1<<AW)-1];
	logic        mem_we;
	logic [AW:0] wr_addr, rd_addr;
	logic [AW-1:0] src_addr;
	logic [23:0] rd_data;
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= {b_q, g_q, r_q};
		rd_data <= mem[rd_addr];
	end
	assign src_addr = AW'(AW'(my_q[YW-1:0]) * AW'(w_q)) + AW'(mx_q[XW-1:0]);
	assign rd_addr  = {~bank_q, src_addr};
	assign wr_addr  = {bank_q, AW'(p_q)};

	// p / w by shift-subtract: quotient is y, remainder is x
	logic [NW-1:0] div_diff;
	logic          div_ge;
	assign div_diff = rem_q - dsr_q;
	assign div_ge   = (rem_q >= dsr_q);

	// shared MAC: dx2*cos, -dy2*sin, then dx2*sin, dy2*cos
	logic signed [DW-1:0] dx2, dy2, mac_a;
	logic signed [COEFF_W-1:0] mac_b;
	logic mac_clr, mac_en, mac_neg;
	logic signed [ACC_W-1:0] mac_init, acc;
	assign dx2 = DW'({1'b0, rem_q[XW-1:0], 1'b0}) - DW'(w_q);
	assign dy2 = DW'({1'b0, y_q, 1'b0}) - DW'(h_q);
	always_comb begin
		mac_clr = 1'b0; mac_en = 1'b0; mac_neg = 1'b0;
		mac_a = dx2; mac_b = cos_q;
		mac_init = ACC_W'(w_q) <<< COEFF_FRAC_BITS;
		case (st_q)
			ST_DIV:  mac_clr = 1'b1;
			ST_M0:   mac_en = 1'b1;
			ST_M1:   begin mac_en = 1'b1; mac_neg = 1'b1; mac_a = dy2; mac_b = sin_q; end
			ST_M2:   begin
				mac_clr = 1'b1; mac_init = ACC_W'(h_q) <<< COEFF_FRAC_BITS;
			end
			ST_M3:   begin mac_en = 1'b1; mac_a = dx2; mac_b = sin_q; end
			ST_M4:   begin mac_en = 1'b1; mac_a = dy2; mac_b = cos_q; end
			default: ;
		endcase
	end
	rpre_mac #(.A_W(DW), .ACC_W(ACC_W)) u_mac (
		.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b),
		.neg(mac_neg), .init(mac_init), .acc(acc)
	);

	// residuals against the prediction read in ST_RD
	logic [3:0] nr, ng, nb;
	assign nr = resid_nib(r_q, rd_data[7:0]);
	assign ng = resid_nib(g_q, rd_data[15:8]);
	assign nb = resid_nib(b_q, rd_data[23:16]);

	// wrap: shared add/subtract, x first, then y
	logic signed [FW-1:0] w_s, h_s, mod_a, mod_b, mod_sum;
	logic mx_ok, my_ok;
	assign w_s = FW'(w_q);
	assign h_s = FW'(h_q);
	assign mx_ok = (mx_q >= 0) && (mx_q < w_s);
	assign my_ok = (my_q >= 0) && (my_q < h_s);
	always_comb begin
		if (!mx_ok) begin
			mod_a = mx_q;
			mod_b = (mx_q < 0) ? w_s : -w_s;
		end else begin
			mod_a = my_q;
			mod_b = (my_q < 0) ? h_s : -h_s;
		end
	end
	assign mod_sum = mod_a + mod_b;

	assign s_tready = (st_q == ST_IDLE);
	assign mem_we   = (st_q == ST_RES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(64); height_q <= DIM_W'(64);
			cos_q <= 16'sd16384; sin_q <= '0;
			bank_q <= 1'b0; pix_q <= '0; held_q <= '0;
			st_q <= ST_IDLE; ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					REG_COS:    cos_q    <= cfg_data;
					REG_SIN:    sin_q    <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: if (s_tvalid) st_q <= (s_tuser == CMD_KEY) ? ST_RES : ST_DIV;
				ST_DIV: if (dcnt_q == '0) st_q <= ST_M0;
				ST_M0:  st_q <= ST_M1;
				ST_M1:  st_q <= ST_M2;
				ST_M2:  st_q <= ST_M3;
				ST_M3:  st_q <= ST_M4;
				ST_M4:  st_q <= ST_MY;
				ST_MY:  st_q <= ST_MX;
				ST_MX:  if (mx_ok && my_ok) st_q <= ST_RD;
				ST_RD:  st_q <= ST_RES;
				ST_RES: begin
					st_q <= ST_OUT0; ov_q <= 1'b1;
					if (cmd_q == CMD_INTER && !p_q[0]) held_q <= nb;
					if (end_q) begin pix_q <= '0; bank_q <= ~bank_q; end
					else pix_q <= p_q + NW'(1);
				end
				ST_OUT0: if (m_tready) begin
					if (two_q) st_q <= ST_OUT1;
					else begin st_q <= ST_IDLE; ov_q <= 1'b0; end
				end
				ST_OUT1: if (m_tready) begin st_q <= ST_IDLE; ov_q <= 1'b0; end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cmd_q <= s_tuser;
				r_q <= s_tdata[7:0]; g_q <= s_tdata[15:8]; b_q <= s_tdata[23:16];
				p_q <= p_eff; npix_q <= npix_eff;
				w_q <= w_eff; h_q <= h_eff;
				end_q <= (p_eff == npix_eff - NW'(1));
				rem_q <= p_eff;
				dsr_q <= NW'(w_eff) << (YW - 1);
				dcnt_q <= 4'(YW - 1);
				y_q <= '0;
			end
			ST_DIV: begin
				if (div_ge) rem_q <= div_diff;
				y_q <= YW'({y_q, div_ge});
				dsr_q <= dsr_q >> 1;
				dcnt_q <= dcnt_q - 4'd1;
			end
			ST_M2: mx_q <= FW'(acc >>> SH);
			ST_MY: my_q <= FW'(acc >>> SH);
			ST_MX: begin
				if (!mx_ok) mx_q <= mod_sum;
				else if (!my_ok) my_q <= mod_sum;
			end
			ST_RES: begin
				if (cmd_q == CMD_KEY) begin
					ob_q <= {r_q[7:3], g_q[7:5]};
					ob2_q <= {g_q[4:2], b_q[7:3]};
					off_q <= OFF_W'({p_q, 1'b0});
					off2_q <= OFF_W'({p_q, 1'b1});
					done_q <= 1'b0; done2_q <= end_q; two_q <= 1'b1;
				end else begin
					ob_q <= {nr, ng}; off_q <= OFF_W'(p_q);
					ob2_q <= {held_q, nb};
					off2_q <= OFF_W'(npix_q + (p_q >> 1));
					two_q <= p_q[0];
					done_q <= p_q[0] ? 1'b0 : end_q;
					done2_q <= end_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = ov_q && (st_q == ST_OUT0 || st_q == ST_OUT1);
	logic is2;
	assign is2 = (st_q == ST_OUT1);
	assign m_tdata = {2'b00, (is2 ? done2_q : done_q), (is2 ? off2_q : off_q),
		(is2 ? ob2_q : ob_q)};
	assign m_tlast = is2 || !two_q;
endmodule

// ----- src/rpre_checker.sv -----
// ----------------------------------------------------------------------------
// rpre_checker
// Port-level checks of the rotation predicted residual encoder.
// ----------------------------------------------------------------------------
`include "rotation_predicted_residual_encoder_defines.svh"
module rpre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);
	`RPRE_ASSERT_IMPL(a_no_in_while_out, clk, arst_n, m_tvalid, !s_tready, "input taken while result pending")
	`RPRE_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken back to back")
	`RPRE_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
	`RPRE_ASSERT_IMPL(a_done_last, clk, arst_n, m_tvalid && m_tdata[21], m_tlast, "frame end not last")
endmodule

bind rotation_predicted_residual_encoder rpre_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ----- sim/tb_rotation_predicted_residual_encoder.sv -----
// ----------------------------------------------------------------------------
// tb_rotation_predicted_residual_encoder
// Self-checking bench: a directed pixel table, then random frames over many
// frame sizes and rotations, each coded byte checked against an in-bench
// encoder model.
// ----------------------------------------------------------------------------
module tb_rotation_predicted_residual_encoder;
	import rpre_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 4096;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TARGET_PIXELS = 1900;

	// one coded byte as it should leave the block
	typedef struct {
		logic [7:0]  code;
		logic [12:0] offset;
		logic        done;
		logic        tail;
	} coded_byte_t;

	// directed pixel row; typed rows carry the bytes read off by hand
	typedef struct {
		logic       cmd;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit         typed;
		logic [7:0] code0;
		logic [7:0] code1;
	} pixel_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // out_byte[7:0], byte_offset[20:8], frame_done[21]
	logic        m_tlast;   // last

	rotation_predicted_residual_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// encoder model state
	logic [6:0]         enc_width;
	logic [6:0]         enc_height;
	logic signed [15:0] enc_cos;
	logic signed [15:0] enc_sin;
	logic [23:0]        pixel_store [2][STORE_DEPTH];
	bit                 pixel_known [2][STORE_DEPTH];
	bit                 write_bank;
	int                 next_pixel;
	logic [3:0]         held_blue;

	coded_byte_t coded_q[$];
	int          errors;
	int          pixels_sent;
	int          cycles;
	bit          long_stall_done;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic [3:0] residual_nibble(input logic [7:0] cur, input logic [7:0] pr);
		logic [8:0] diff;
		diff = {1'b0, cur} + 9'd256 - {1'b0, pr};
		return diff[7:4] + 4'd8;
	endfunction

	// Code one pixel and queue its bytes. An inter pixel whose prediction
	// would read a store entry never written is turned into a key pixel.
	task automatic encode_pixel(inout logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input bit typed, input logic [7:0] code0,
			input logic [7:0] code1);
		int          w, h, npix, p, src;
		bit          end_px;
		longint      x, y, dx2, dy2, rx, ry, px, py;
		logic [23:0] pred;
		logic [3:0]  nr, ng, nb;
		coded_byte_t c0, c1;
		w = enc_width;
		h = enc_height;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
		npix = w * h;
		if (next_pixel >= npix) next_pixel = 0;
		p = next_pixel;
		end_px = (p == npix - 1);
		x = p % w;
		y = p / w;
		dx2 = 2 * x - w;
		dy2 = 2 * y - h;
		rx = dx2 * longint'(enc_cos) - dy2 * longint'(enc_sin) + (longint'(w) << 14);
		ry = dx2 * longint'(enc_sin) + dy2 * longint'(enc_cos) + (longint'(h) << 14);
		px = (rx >>> 15) % w;
		py = (ry >>> 15) % h;
		if (px < 0) px += w;
		if (py < 0) py += h;
		src = int'(py * w + px) % STORE_DEPTH;
		if (cmd == CMD_INTER && !pixel_known[!write_bank][src])
			cmd = CMD_KEY;
		if (cmd == CMD_KEY) begin
			c0 = '{{r[7:3], g[7:5]}, 13'(2 * p), 1'b0, 1'b0};
			c1 = '{{g[4:2], b[7:3]}, 13'(2 * p + 1), end_px, 1'b1};
			if (typed) begin
				c0.code = code0;
				c1.code = code1;
			end
			coded_q.push_back(c0);
			coded_q.push_back(c1);
		end else begin
			pred = pixel_store[!write_bank][src];
			nr = residual_nibble(r, pred[23:16]);
			ng = residual_nibble(g, pred[15:8]);
			nb = residual_nibble(b, pred[7:0]);
			if (p % 2 == 0) begin
				held_blue = nb;
				c0 = '{{nr, ng}, 13'(p), end_px, 1'b1};
				if (typed) c0.code = code0;
				coded_q.push_back(c0);
			end else begin
				c0 = '{{nr, ng}, 13'(p), 1'b0, 1'b0};
				c1 = '{{held_blue, nb}, 13'(npix + p / 2), end_px, 1'b1};
				if (typed) begin
					c0.code = code0;
					c1.code = code1;
				end
				coded_q.push_back(c0);
				coded_q.push_back(c1);
			end
		end
		pixel_store[write_bank][p] = {r, g, b};
		pixel_known[write_bank][p] = 1'b1;
		if (end_px) begin
			next_pixel = 0;
			write_bank = !write_bank;
		end else begin
			next_pixel = p + 1;
		end
	endtask

	// register writes only with the block drained and quiet
	task automatic set_regs(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] c, input logic [15:0] s);
		wait (coded_q.size() == 0);
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_COS;
		cfg_data <= c;
		@(posedge clk);
		cfg_index <= REG_SIN;
		cfg_data <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		enc_width = w[6:0];
		enc_height = h[6:0];
		enc_cos = c;
		enc_sin = s;
	endtask

	// sender bursts: random burst length, random gap after it
	int burst_left;

	task automatic send_pixel(input logic cmd_in, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input bit typed, input logic [7:0] code0,
			input logic [7:0] code1);
		logic cmd;
		int   gap;
		cmd = cmd_in;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		encode_pixel(cmd, r, g, b, typed, code0, code1);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {b, g, r};
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	task automatic idle_sender();
		s_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'd0;
			3: return 16'h7FFF;
			4: return 16'h8000;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	pixel_row_t directed [24] = '{
		// key frame 4x2, RGB565 by hand
		'{CMD_KEY, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF, 8'hFF},
		'{CMD_KEY, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00},
		'{CMD_KEY, 8'hF8, 8'h00, 8'h00, 1, 8'hF8, 8'h00},
		'{CMD_KEY, 8'h00, 8'hFC, 8'h00, 1, 8'h07, 8'hE0},
		'{CMD_KEY, 8'h00, 8'h00, 8'hF8, 1, 8'h00, 8'h1F},
		'{CMD_KEY, 8'h07, 8'h03, 8'h07, 1, 8'h00, 8'h00},
		'{CMD_KEY, 8'h10, 8'h20, 8'h08, 1, 8'h11, 8'h01},
		'{CMD_KEY, 8'hAA, 8'h55, 8'hCC, 1, 8'hAA, 8'hB9},
		// same frame as inter under identity rotation: zero residual
		'{CMD_INTER, 8'hFF, 8'hFF, 8'hFF, 1, 8'h88, 8'h00},
		'{CMD_INTER, 8'h00, 8'h00, 8'h00, 1, 8'h88, 8'h88},
		'{CMD_INTER, 8'hF8, 8'h00, 8'h00, 1, 8'h88, 8'h00},
		'{CMD_INTER, 8'h00, 8'hFC, 8'h00, 1, 8'h88, 8'h88},
		'{CMD_INTER, 8'h00, 8'h00, 8'hF8, 1, 8'h88, 8'h00},
		'{CMD_INTER, 8'h07, 8'h03, 8'h07, 1, 8'h88, 8'h88},
		'{CMD_INTER, 8'h10, 8'h20, 8'h08, 1, 8'h88, 8'h00},
		'{CMD_INTER, 8'hAA, 8'h55, 8'hCC, 1, 8'h88, 8'h88},
		// full-swing residuals, key pixel mixed in for a stale held nibble
		'{CMD_INTER, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00},
		'{CMD_INTER, 8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 8'h00},
		'{CMD_INTER, 8'hFF, 8'h00, 8'hFF, 0, 8'h00, 8'h00},
		'{CMD_INTER, 8'h00, 8'hFF, 8'h00, 0, 8'h00, 8'h00},
		'{CMD_KEY,   8'h5A, 8'hA5, 8'h3C, 0, 8'h00, 8'h00},
		'{CMD_INTER, 8'h80, 8'h7F, 8'h01, 0, 8'h00, 8'h00},
		'{CMD_INTER, 8'h01, 8'h80, 8'hFE, 0, 8'h00, 8'h00},
		'{CMD_INTER, 8'hC3, 8'h3C, 8'h99, 0, 8'h00, 8'h00}
	};

	// stimulus
	initial begin
		int phase, frames, npix, k, w, h;
		logic [15:0] pw, ph;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_KEY;
		enc_width = 7'd64;
		enc_height = 7'd64;
		enc_cos = 16'sd16384;
		enc_sin = '0;
		write_bank = 1'b0;
		next_pixel = 0;
		held_blue = '0;
		errors = 0;
		pixels_sent = 0;
		burst_left = 0;
		foreach (pixel_known[i, j]) pixel_known[i][j] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(16'd4, 16'd2, 16'sd16384, 16'd0);
		foreach (directed[i])
			send_pixel(directed[i].cmd, directed[i].r, directed[i].g, directed[i].b,
				directed[i].typed, directed[i].code0, directed[i].code1);
		idle_sender();

		// random phases: fixed extremes first, then random sizes and angles
		phase = 0;
		while (pixels_sent < TARGET_PIXELS) begin
			case (phase)
				0: set_regs(16'd0, 16'd0, 16'h7FFF, 16'h8000);
				1: set_regs(16'd64, 16'd1, -16'sd16384, 16'd0);
				2: set_regs(16'd1, 16'd64, 16'd0, 16'sd16384);
				3: set_regs(16'd127, 16'd2, 16'd0, -16'sd16384);
				4: set_regs(16'd3, 16'd5, 16'h8000, 16'h7FFF);
				default: begin
					pw = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 127))
						: 16'($urandom_range(1, 9));
					ph = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3))
						: 16'($urandom_range(1, 9));
					set_regs(pw, ph, pick_coeff(), pick_coeff());
				end
			endcase
			w = (enc_width == 0) ? 1 : (enc_width > 64) ? 64 : enc_width;
			h = (enc_height == 0) ? 1 : (enc_height > 64) ? 64 : enc_height;
			npix = w * h;
			// key frame, then inter frames; some noise and broken frames
			frames = $urandom_range(2, 5);
			for (int f = 0; f < frames; f++) begin
				k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, npix) : npix;
				for (int i = 0; i < k && pixels_sent < TARGET_PIXELS; i++)
					send_pixel((f == 0) ? CMD_KEY
						: ($urandom_range(0, 9) == 0) ? CMD_KEY : CMD_INTER,
						8'($urandom), 8'($urandom), 8'($urandom), 0, 8'h00, 8'h00);
			end
			idle_sender();
			phase++;
		end

		wait (coded_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// receiver: stall pattern changes every so often; one long hold-off
	initial begin
		int mode, span, hold;
		m_tready = 1'b0;
		long_stall_done = 1'b0;
		forever begin
			if (!long_stall_done && pixels_sent >= 400) begin
				long_stall_done = 1'b1;
				hold = 600;
				while (hold > 0) begin
					m_tready <= 1'b0;
					@(posedge clk);
					hold--;
				end
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom);
					2: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= ($urandom_range(0, 4) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// check every transaction on the output side against the oldest byte
	always @(posedge clk) begin
		coded_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (coded_q.size() == 0) begin
				report("unexpected byte", m_tdata, 0);
			end else begin
				want = coded_q.pop_front();
				if (m_tdata[7:0] !== want.code) report("out_byte", m_tdata[7:0], want.code);
				if (m_tdata[20:8] !== want.offset)
					report("byte_offset", m_tdata[20:8], want.offset);
				if (m_tdata[21] !== want.done) report("frame_done", m_tdata[21], want.done);
				if (m_tlast !== want.tail) report("last", m_tlast, want.tail);
			end
		end
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end
endmodule
